// ===== hdl/tes_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Timed event scheduler package
// Shared widths, opcodes, result kinds, the controller states and the chain operation type.
// ----------------------------------------------------------------------------
package tes_pkg;

  localparam int EVENT_SLOTS = 16;
  localparam int TIME_BITS   = 48;
  localparam int MAX_FIRES   = 16;
  localparam int RESULT_CAP  = 16;
  localparam int ID_BITS     = 4;
  localparam int IVL_BITS    = 32;
  localparam int OUT_TIME_BITS = 48;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_FIRE   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_REMOVE,
    ST_FIRE,
    ST_REPLY
  } state_t;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CH_HOLD,
    CH_INSERT,
    CH_DELETE
  } chain_op_t;

endpackage
`default_nettype wire

// ===== hdl/timed_event_scheduler_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Timed event scheduler
// Sorted chain of timed events with id recycling and a firing sweep.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata (low bit up)                          tuser  tlast
// s_axis   in   due_time[47:0] repeat_interval[79:48]       opcode none
//               event_id[83:80]
// m_axis   out  assigned_id[3:0] fired_time[51:4] ok[52]    kind   last
//
// Add and remove are accepted, then act on the chain; the reply beat is
// registered at the end of the chain step and the next input waits for it
// to leave. A tick is accepted, then sweeps the due events off the head, with
// a re-entry step for each repeating one, and closes once no event is due or
// the budget is spent. Each fired beat is held while the sweep looks at the
// new head so that its last flag is known. Reset clears the chain valid bits,
// time and id counters at once. A stalled output holds the sweep in place.
// ----------------------------------------------------------------------------
module timed_event_scheduler_top #(
  parameter int TIME_BITS   = tes_pkg::TIME_BITS,
  parameter int MAX_FIRES   = tes_pkg::MAX_FIRES
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // due_time[47:0], repeat_interval[79:48], event_id[83:80], zero pad
  input  wire [87:0]  s_axis_tdata,
  // opcode[1:0]
  input  wire [1:0]   s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // assigned_id[3:0], fired_time[51:4], ok[52], zero pad
  output logic [55:0] m_axis_tdata,
  // kind[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int EVENT_SLOTS = tes_pkg::EVENT_SLOTS;
  localparam int SLOT_BITS   = $clog2(EVENT_SLOTS);
  localparam int FIRE_CAP = (MAX_FIRES < tes_pkg::RESULT_CAP) ? MAX_FIRES
                                                              : tes_pkg::RESULT_CAP;
  localparam int FC_BITS  = $clog2(FIRE_CAP + 1);
  localparam int SP_BITS  = $clog2(EVENT_SLOTS + 1);
  localparam int SUM_BITS = ((TIME_BITS > tes_pkg::IVL_BITS) ? TIME_BITS
                                                             : tes_pkg::IVL_BITS) + 1;
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  tes_pkg::state_t state, state_next;
  tes_pkg::chain_op_t cop;

  logic [TIME_BITS-1:0] cur_time, in_due, ins_due;
  logic [tes_pkg::IVL_BITS-1:0] in_ivl, ins_ivl;
  logic [tes_pkg::ID_BITS-1:0]  in_id, ins_id, del_id;
  logic [FC_BITS-1:0] fires;
  logic [SP_BITS-1:0] free_cnt, fresh;
  logic [tes_pkg::ID_BITS-1:0] free_stack [EVENT_SLOTS];
  logic full, found, hv;
  logic [TIME_BITS-1:0] hd;
  logic [tes_pkg::IVL_BITS-1:0] hi;
  logic [tes_pkg::ID_BITS-1:0] hid;
  logic fire_now, reinsert, out_free, sweep_go;
  logic [SUM_BITS-1:0] sum;
  logic sat;
  logic pend;
  logic [tes_pkg::OUT_TIME_BITS-1:0] pend_time;
  logic out_load, out_ok, out_last;
  logic [1:0] out_kind;
  logic [tes_pkg::ID_BITS-1:0] out_id;
  logic [tes_pkg::OUT_TIME_BITS-1:0] out_time;

  tes_chain #(.EVENT_SLOTS(EVENT_SLOTS), .TIME_BITS(TIME_BITS)) u_chain (
    .clk(clk), .rst(rst), .op(cop),
    .new_due(ins_due), .new_ivl(ins_ivl), .new_id(ins_id), .del_id(del_id),
    .full(full), .found(found), .head_valid(hv), .head_due(hd),
    .head_ivl(hi), .head_id(hid)
  );

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == tes_pkg::ST_IDLE) && !m_axis_tvalid;
  // Head is due and the firing budget is not spent.
  assign fire_now = hv && (hd <= cur_time) && (fires < FC_BITS'(FIRE_CAP));
  // The sweep moves when no fired beat is held or the held one can leave.
  assign sweep_go = !pend || out_free;
  // Re-entry time saturates at the largest time value.
  assign sum      = SUM_BITS'(hd) + SUM_BITS'(hi);
  assign sat      = sum > SUM_BITS'(TMAX);
  // The sweep always deletes the head; remove looks up the requested id.
  assign del_id   = (state == tes_pkg::ST_FIRE) ? hid : in_id;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      tes_pkg::ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          case (s_axis_tuser)
            tes_pkg::OP_ADD:    state_next = tes_pkg::ST_INSERT;
            tes_pkg::OP_REMOVE: state_next = tes_pkg::ST_REMOVE;
            tes_pkg::OP_TICK:   state_next = tes_pkg::ST_FIRE;
            default:            state_next = tes_pkg::ST_IDLE;
          endcase
        end
      end
      tes_pkg::ST_INSERT, tes_pkg::ST_REMOVE: state_next = tes_pkg::ST_IDLE;
      tes_pkg::ST_FIRE: begin
        if (sweep_go) begin
          if (!fire_now) state_next = tes_pkg::ST_IDLE;
          else if (hi != '0) state_next = tes_pkg::ST_REPLY;
        end
      end
      tes_pkg::ST_REPLY: state_next = tes_pkg::ST_FIRE;
      default: state_next = tes_pkg::ST_IDLE;
    endcase
  end

  // Chain command and insert payload.
  assign reinsert = (state == tes_pkg::ST_REPLY);
  always_comb begin
    cop     = tes_pkg::CH_HOLD;
    ins_due = in_due;
    ins_ivl = in_ivl;
    ins_id  = (free_cnt != '0) ? free_stack[free_cnt[SLOT_BITS-1:0] - 1'b1]
                               : fresh[tes_pkg::ID_BITS-1:0];
    if (reinsert) begin
      ins_due = in_due;
      ins_ivl = in_ivl;
      ins_id  = in_id;
    end
    case (state)
      tes_pkg::ST_INSERT: if (!full) cop = tes_pkg::CH_INSERT;
      tes_pkg::ST_REMOVE: cop = tes_pkg::CH_DELETE;
      tes_pkg::ST_FIRE:   if (sweep_go && fire_now) cop = tes_pkg::CH_DELETE;
      tes_pkg::ST_REPLY:  cop = tes_pkg::CH_INSERT;
      default: ;
    endcase
  end

  // Output beat contents. A held fired beat is last when no firing follows.
  always_comb begin
    out_load = 1'b0;
    out_kind = tes_pkg::KIND_ADD;
    out_id   = '0;
    out_time = '0;
    out_ok   = 1'b0;
    out_last = 1'b1;
    case (state)
      tes_pkg::ST_INSERT: begin
        out_load = 1'b1;
        out_kind = tes_pkg::KIND_ADD;
        if (!full) begin
          out_id = ins_id;
          out_ok = 1'b1;
        end
      end
      tes_pkg::ST_REMOVE: begin
        out_load = 1'b1;
        out_kind = tes_pkg::KIND_REMOVE;
        out_id   = in_id;
        out_ok   = found;
      end
      tes_pkg::ST_FIRE: begin
        if (pend && out_free) begin
          out_load = 1'b1;
          out_kind = tes_pkg::KIND_FIRE;
          out_id   = in_id;
          out_time = pend_time;
          out_ok   = 1'b1;
          out_last = !fire_now;
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tuser <= out_kind;
      m_axis_tlast <= out_last;
      m_axis_tdata <= {3'b000, out_ok, out_time, out_id};
    end
  end

  // Control registers, id bookkeeping and the held fired beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tes_pkg::ST_IDLE;
      cur_time <= '0;
      free_cnt <= '0;
      fresh <= '0;
      fires <= '0;
      pend <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        tes_pkg::ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            in_due <= TIME_BITS'(s_axis_tdata[47:0]);
            in_ivl <= s_axis_tdata[79:48];
            in_id  <= s_axis_tdata[83:80];
            fires  <= '0;
            if (s_axis_tuser == tes_pkg::OP_TICK && cur_time != TMAX)
              cur_time <= cur_time + 1'b1;
          end
        end
        tes_pkg::ST_INSERT: begin
          if (!full) begin
            if (free_cnt != '0) free_cnt <= free_cnt - 1'b1;
            else fresh <= fresh + 1'b1;
          end
        end
        tes_pkg::ST_REMOVE: begin
          if (found) begin
            free_stack[free_cnt[SLOT_BITS-1:0]] <= in_id;
            free_cnt <= free_cnt + 1'b1;
          end
        end
        tes_pkg::ST_FIRE: begin
          if (sweep_go) begin
            if (fire_now) begin
              pend      <= 1'b1;
              pend_time <= tes_pkg::OUT_TIME_BITS'(hd);
              fires     <= fires + 1'b1;
              // Keep the head for its beat and a possible re-entry.
              in_id  <= hid;
              in_ivl <= hi;
              in_due <= sat ? TMAX : sum[TIME_BITS-1:0];
              if (hi == '0) begin
                free_stack[free_cnt[SLOT_BITS-1:0]] <= hid;
                free_cnt <= free_cnt + 1'b1;
              end
            end else begin
              pend <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // The free stack never exceeds the table size.
  a_free: assert property (@(posedge clk) disable iff (rst)
    free_cnt <= SP_BITS'(EVENT_SLOTS)) else $error("free stack overflow");
  // Input is refused while a beat waits.
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready while busy");
  // Firings stay within the budget.
  a_cap: assert property (@(posedge clk) disable iff (rst)
    fires <= FC_BITS'(FIRE_CAP)) else $error("fire budget exceeded");
`endif

endmodule
`default_nettype wire

// ===== hdl/tes_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Timed event scheduler chain cell
// Holds one event and shifts toward or away from its neighbors on insert
// and delete, keeping the chain sorted by due time.
// ----------------------------------------------------------------------------
module tes_cell #(
  parameter int TIME_BITS = tes_pkg::TIME_BITS
) (
  input  wire                             clk,
  input  wire                             rst,
  input  tes_pkg::chain_op_t              op,
  input  wire [TIME_BITS-1:0]             new_due,
  input  wire [tes_pkg::IVL_BITS-1:0]     new_ivl,
  input  wire [tes_pkg::ID_BITS-1:0]      new_id,
  input  wire                             del_hit_in,
  input  wire [tes_pkg::ID_BITS-1:0]      del_id,
  // neighbor below (lower slot, earlier)
  input  wire                             prev_valid,
  input  wire                             prev_after,
  input  wire [TIME_BITS-1:0]             prev_due,
  input  wire [tes_pkg::IVL_BITS-1:0]     prev_ivl,
  input  wire [tes_pkg::ID_BITS-1:0]      prev_id,
  // neighbor above (higher slot)
  input  wire                             nxt_valid,
  input  wire [TIME_BITS-1:0]             nxt_due,
  input  wire [tes_pkg::IVL_BITS-1:0]     nxt_ivl,
  input  wire [tes_pkg::ID_BITS-1:0]      nxt_id,
  output logic                            valid,
  output logic                            after,
  output logic                            del_hit_out,
  output logic [TIME_BITS-1:0]            due,
  output logic [tes_pkg::IVL_BITS-1:0]    ivl,
  output logic [tes_pkg::ID_BITS-1:0]     id
);

  logic match;

  // This cell lies after the insert point when it holds a later due time.
  assign after       = valid && (due > new_due);
  // A delete hit at or below this cell pulls the upper entries down.
  assign match       = valid && (id == del_id);
  assign del_hit_out = del_hit_in || match;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (op)
        // The chain grows by one: the first empty cell above a valid one fills.
        tes_pkg::CH_INSERT: begin
          valid <= valid || prev_valid;
        end
        tes_pkg::CH_DELETE: begin
          if (del_hit_out) valid <= nxt_valid;
        end
        default: ;
      endcase
    end
  end

  // Payload moves with the shift.
  always_ff @(posedge clk) begin
    case (op)
      tes_pkg::CH_INSERT: begin
        if (prev_after) begin
          due <= prev_due;
          ivl <= prev_ivl;
          id  <= prev_id;
        end else if (after || !valid) begin
          due <= new_due;
          ivl <= new_ivl;
          id  <= new_id;
        end
      end
      tes_pkg::CH_DELETE: begin
        if (del_hit_out) begin
          due <= nxt_due;
          ivl <= nxt_ivl;
          id  <= nxt_id;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/tes_chain.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Timed event scheduler chain
// A row of cells holding the events sorted by due time, slot 0 earliest.
// ----------------------------------------------------------------------------
module tes_chain #(
  parameter int EVENT_SLOTS = tes_pkg::EVENT_SLOTS,
  parameter int TIME_BITS   = tes_pkg::TIME_BITS
) (
  input  wire                          clk,
  input  wire                          rst,
  input  tes_pkg::chain_op_t           op,
  input  wire [TIME_BITS-1:0]          new_due,
  input  wire [tes_pkg::IVL_BITS-1:0]  new_ivl,
  input  wire [tes_pkg::ID_BITS-1:0]   new_id,
  input  wire [tes_pkg::ID_BITS-1:0]   del_id,
  output logic                         full,
  output logic                         found,
  output logic                         head_valid,
  output logic [TIME_BITS-1:0]         head_due,
  output logic [tes_pkg::IVL_BITS-1:0] head_ivl,
  output logic [tes_pkg::ID_BITS-1:0]  head_id
);

  logic [EVENT_SLOTS-1:0] v, aft, hit;
  logic [TIME_BITS-1:0]   d [EVENT_SLOTS];
  logic [tes_pkg::IVL_BITS-1:0] iv [EVENT_SLOTS];
  logic [tes_pkg::ID_BITS-1:0]  ids [EVENT_SLOTS];

  // Cells in a row; each looks only at its two neighbors.
  for (genvar g = 0; g < EVENT_SLOTS; g++) begin : g_cell
    logic pv, pa, hin, nv;
    logic [TIME_BITS-1:0] pd, nd;
    logic [tes_pkg::IVL_BITS-1:0] pi, ni;
    logic [tes_pkg::ID_BITS-1:0] pid, nid;
    if (g == 0) begin : g_lo
      assign pv = 1'b1; assign pa = 1'b0; assign hin = 1'b0;
      assign pd = '0; assign pi = '0; assign pid = '0;
    end else begin : g_mid
      assign pv = v[g-1]; assign pa = aft[g-1]; assign hin = hit[g-1];
      assign pd = d[g-1]; assign pi = iv[g-1]; assign pid = ids[g-1];
    end
    if (g == EVENT_SLOTS-1) begin : g_hi
      assign nv = 1'b0; assign nd = '0; assign ni = '0; assign nid = '0;
    end else begin : g_up
      assign nv = v[g+1]; assign nd = d[g+1]; assign ni = iv[g+1]; assign nid = ids[g+1];
    end
    tes_cell #(.TIME_BITS(TIME_BITS)) u_cell (
      .clk(clk), .rst(rst), .op(op),
      .new_due(new_due), .new_ivl(new_ivl), .new_id(new_id),
      .del_hit_in(hin), .del_id(del_id),
      .prev_valid(pv), .prev_after(pa), .prev_due(pd), .prev_ivl(pi), .prev_id(pid),
      .nxt_valid(nv), .nxt_due(nd), .nxt_ivl(ni), .nxt_id(nid),
      .valid(v[g]), .after(aft[g]), .del_hit_out(hit[g]),
      .due(d[g]), .ivl(iv[g]), .id(ids[g])
    );
  end

  assign full       = v[EVENT_SLOTS-1];
  assign found      = hit[EVENT_SLOTS-1];
  assign head_valid = v[0];
  assign head_due   = d[0];
  assign head_ivl   = iv[0];
  assign head_id    = ids[0];

`ifndef SYNTHESIS
  // Valid slots stay contiguous from slot 0.
  for (genvar k = 1; k < EVENT_SLOTS; k++) begin : g_chk
    a_contig: assert property (@(posedge clk) disable iff (rst) v[k] |-> v[k-1])
      else $error("chain gap at slot %0d", k);
  end
  // The head is never due later than slot 1.
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    v[1] |-> (d[0] <= d[1])) else $error("chain out of order");
  // A delete without a hit leaves the row alone.
  a_delnop: assert property (@(posedge clk) disable iff (rst)
    (op == tes_pkg::CH_DELETE && !found) |=> $stable(v))
    else $error("delete miss changed chain");
`endif

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timed event scheduler testbench
// Drives add, remove, tick and unused-opcode beats with random gaps, predicts replies and
// firings from a behavioral copy of the sorted event chain, and checks every
// output beat field by field in order.
// ----------------------------------------------------------------------------
module tb;

  localparam longint unsigned TMAX = 64'hFFFF_FFFF_FFFF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [47:0] due_time;
    logic [31:0] repeat_interval;
    logic [3:0]  event_id;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  id;
    logic [47:0] fired_time;
    logic        ok;
    logic        last;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  cmd_t   pending_cmds[$];
  reply_t expected_replies[$];
  int     mismatches = 0;
  int     idle_cycles = 0;
  bit     hold_off_req = 1'b0;
  bit     hold_off_done = 1'b0;
  int     send_gap = 0;
  int     recv_gap = 0;
  int     hold_off_left = 0;

  // Shadow copy of the chain and the id bookkeeping.
  logic [47:0] sh_time = '0;
  logic [47:0] sh_due[tes_pkg::EVENT_SLOTS];
  logic [31:0] sh_ivl[tes_pkg::EVENT_SLOTS];
  logic [3:0]  sh_id[tes_pkg::EVENT_SLOTS];
  int          sh_count = 0;
  logic [3:0]  sh_free[tes_pkg::EVENT_SLOTS];
  int          sh_free_count = 0;
  int          sh_fresh = 0;

  timed_event_scheduler_top dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic void chain_put(logic [47:0] due, logic [31:0] ivl, logic [3:0] id);
    int pos;
    pos = 0;
    while (pos < sh_count && sh_due[pos] <= due) pos++;
    for (int i = sh_count; i > pos; i--) begin
      sh_due[i] = sh_due[i-1];
      sh_ivl[i] = sh_ivl[i-1];
      sh_id[i]  = sh_id[i-1];
    end
    sh_due[pos] = due;
    sh_ivl[pos] = ivl;
    sh_id[pos]  = id;
    sh_count++;
  endfunction

  function automatic void chain_drop(int pos);
    for (int i = pos; i + 1 < sh_count; i++) begin
      sh_due[i] = sh_due[i+1];
      sh_ivl[i] = sh_ivl[i+1];
      sh_id[i]  = sh_id[i+1];
    end
    sh_count--;
  endfunction

  function automatic void push_expect(logic [1:0] k, logic [3:0] id, logic [47:0] t,
                                      logic ok, logic last);
    reply_t r;
    r.kind = k; r.id = id; r.fired_time = t; r.ok = ok; r.last = last;
    expected_replies.push_back(r);
  endfunction

  // Works out the beats that one accepted command produces.
  function automatic void schedule_cmd(cmd_t c);
    logic [3:0]  id;
    logic [47:0] due;
    logic [31:0] ivl;
    longint unsigned nd;
    int fires;
    bit found;
    case (c.opcode)
      tes_pkg::OP_ADD: begin
        if (sh_count >= tes_pkg::EVENT_SLOTS) begin
          push_expect(tes_pkg::KIND_ADD, 4'd0, '0, 1'b0, 1'b1);
        end else if (sh_free_count > 0) begin
          sh_free_count--;
          id = sh_free[sh_free_count];
          chain_put(c.due_time, c.repeat_interval, id);
          push_expect(tes_pkg::KIND_ADD, id, '0, 1'b1, 1'b1);
        end else if (sh_fresh < tes_pkg::EVENT_SLOTS) begin
          id = sh_fresh[3:0];
          sh_fresh++;
          chain_put(c.due_time, c.repeat_interval, id);
          push_expect(tes_pkg::KIND_ADD, id, '0, 1'b1, 1'b1);
        end else begin
          push_expect(tes_pkg::KIND_ADD, 4'd0, '0, 1'b0, 1'b1);
        end
      end
      tes_pkg::OP_REMOVE: begin
        found = 1'b0;
        for (int i = 0; i < sh_count && !found; i++) begin
          if (sh_id[i] == c.event_id) begin
            chain_drop(i);
            if (sh_free_count < tes_pkg::EVENT_SLOTS) begin
              sh_free[sh_free_count] = c.event_id;
              sh_free_count++;
            end
            found = 1'b1;
          end
        end
        push_expect(tes_pkg::KIND_REMOVE, c.event_id, '0, found, 1'b1);
      end
      tes_pkg::OP_TICK: begin
        fires = 0;
        if (sh_time != TMAX[47:0]) sh_time = sh_time + 48'd1;
        while (fires < tes_pkg::MAX_FIRES && fires < tes_pkg::RESULT_CAP && sh_count > 0
               && sh_due[0] <= sh_time) begin
          due = sh_due[0]; ivl = sh_ivl[0]; id = sh_id[0];
          push_expect(tes_pkg::KIND_FIRE, id, due, 1'b1, 1'b0);
          fires++;
          chain_drop(0);
          if (ivl != 0) begin
            nd = (64'(ivl) > TMAX - 64'(due)) ? TMAX : 64'(due) + 64'(ivl);
            chain_put(nd[47:0], ivl, id);
          end else if (sh_free_count < tes_pkg::EVENT_SLOTS) begin
            sh_free[sh_free_count] = id;
            sh_free_count++;
          end
        end
        if (fires > 0) expected_replies[$].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Driver: offers queued commands with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        schedule_cmd(pending_cmds.pop_front());
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // Keep the beat on the bus.
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pending_cmds[0].opcode;
        s_axis_tdata  <= {4'd0, pending_cmds[0].event_id,
                          pending_cmds[0].repeat_interval, pending_cmds[0].due_time};
        send_gap <= pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure, one long hold-off on request, and checks.
  always @(posedge clk) begin
    reply_t got, want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser;
        got.id = m_axis_tdata[3:0];
        got.fired_time = m_axis_tdata[51:4];
        got.ok = m_axis_tdata[52];
        got.last = m_axis_tlast;
        if (expected_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat kind=%0d id=%0d t=%0d ok=%0d last=%0d",
                     got.kind, got.id, got.fired_time, got.ok, got.last);
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp kind=%0d id=%0d t=%0d ok=%0d last=%0d,",
                       want.kind, want.id, want.fired_time, want.ok, want.last,
                       " got kind=%0d id=%0d t=%0d ok=%0d last=%0d",
                       got.kind, got.id, got.fired_time, got.ok, got.last);
          end
        end
      end
      if (hold_off_req && !hold_off_done) begin
        hold_off_done <= 1'b1;
        hold_off_left <= 300;
        m_axis_tready <= 1'b0;
      end else if (hold_off_left > 0) begin
        hold_off_left <= hold_off_left - 1;
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_gap <= pick_gap();
      end
    end
  end

  function automatic void queue_cmd(logic [1:0] op, logic [47:0] due, logic [31:0] ivl,
                                    logic [3:0] id);
    cmd_t c;
    c.opcode = op; c.due_time = due; c.repeat_interval = ivl; c.event_id = id;
    pending_cmds.push_back(c);
  endfunction

  function automatic logic [47:0] rand_time();
    return 48'({$urandom(), $urandom()});
  endfunction

  // Stimulus. Times stay near the start except for a few far or saturated ones.
  initial begin
    int r;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // Directed: past due, remove miss, one-shot and repeat firing, unused opcode.
    queue_cmd(tes_pkg::OP_ADD, 48'd0, 32'd0, 4'd0);
    queue_cmd(tes_pkg::OP_ADD, 48'd1, 32'd1, 4'd0);
    queue_cmd(tes_pkg::OP_REMOVE, '0, '0, 4'd15);
    queue_cmd(tes_pkg::OP_TICK, '0, '0, 4'd0);
    queue_cmd(OP_UNUSED, rand_time(), $urandom(), 4'hF);
    queue_cmd(tes_pkg::OP_TICK, '0, '0, 4'd0);
    queue_cmd(tes_pkg::OP_REMOVE, '0, '0, 4'd1);
    queue_cmd(tes_pkg::OP_ADD, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 4'd0);
    // Fill the table to overflow, then fire the newly added events twice.
    for (int i = 0; i < 16; i++) queue_cmd(tes_pkg::OP_ADD, 48'd3, 32'd1, 4'd0);
    queue_cmd(tes_pkg::OP_TICK, '0, '0, 4'd0);
    queue_cmd(tes_pkg::OP_TICK, '0, '0, 4'd0);
    for (int i = 0; i < 16; i++) queue_cmd(tes_pkg::OP_REMOVE, '0, '0, i[3:0]);
    // Long-overdue repeating events so that one tick hits the fire limit.
    for (int i = 0; i < 4; i++) queue_cmd(tes_pkg::OP_ADD, 48'd0, 32'd1, 4'd0);
    queue_cmd(tes_pkg::OP_TICK, '0, '0, 4'd0);
    queue_cmd(tes_pkg::OP_TICK, '0, '0, 4'd0);
    for (int i = 0; i < 16; i++) queue_cmd(tes_pkg::OP_REMOVE, '0, '0, i[3:0]);
    // Long receiver hold-off while the sender keeps going.
    wait (pending_cmds.size() < 30);
    hold_off_req = 1'b1;
    for (int n = 0; n < 240; n++) begin
      r = $urandom_range(0, 99);
      if (r < 35)
        queue_cmd(tes_pkg::OP_ADD,
                  (r < 3) ? rand_time() : sh_time + 48'($urandom_range(0, 8)),
                  (r < 6) ? $urandom() : ((r & 1) ? 32'd0 : 32'($urandom_range(1, 4))),
                  4'($urandom()));
      else if (r < 55)
        queue_cmd(tes_pkg::OP_REMOVE, rand_time(), $urandom(), 4'($urandom()));
      else if (r < 97)
        queue_cmd(tes_pkg::OP_TICK, rand_time(), $urandom(), 4'($urandom()));
      else
        queue_cmd(OP_UNUSED, rand_time(), $urandom(), 4'($urandom()));
      if (pending_cmds.size() > 40) wait (pending_cmds.size() < 20);
    end
    wait (pending_cmds.size() == 0 && !s_axis_tvalid);
    wait (expected_replies.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_replies.size() == 0)
      $display("timed_event_scheduler_top regression: pass");
    else
      $display("timed_event_scheduler_top regression: fail");
    $finish;
  end

  // Watchdog on cycles with no accepted beat.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timed_event_scheduler_top regression: fail");
      $finish;
    end
  end
endmodule

// ===== filelist.f =====
hdl/tes_pkg.sv
hdl/tes_cell.sv
hdl/tes_chain.sv
hdl/timed_event_scheduler_top.sv
test/tb.sv
